// ----- hdl/kdeq_pkg.sv -----
package kdeq_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 8;
    localparam int NUM_KEYS_DEFAULT   = 3;
    localparam int MAX_KEYS           = 8;

    localparam int PIN_W  = 3;
    localparam int CODE_W = 8;

    localparam logic [CODE_W-1:0] DEBOUNCE_RESET = 8'd20;
    localparam logic [CODE_W-1:0] PRESS_BASE     = 8'h30;
    localparam logic [CODE_W-1:0] RELEASE_FLAG   = 8'h80;
    localparam logic [CODE_W-1:0] EMPTY_CODE     = 8'h00;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

endpackage

// ----- hdl/kdeq_ram.sv -----
module kdeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/kdeq_front.sv -----
module kdeq_front #(
    parameter int NUM_KEYS = kdeq_pkg::NUM_KEYS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [kdeq_pkg::CODE_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_cmd,
    input  logic [kdeq_pkg::PIN_W-1:0]    in_pins,
    input  logic                          q_ready,
    output logic                          q_valid,
    output logic [2*NUM_KEYS:0]           q_data
);

    logic [kdeq_pkg::CODE_W-1:0]   ticks_reg;
    logic [kdeq_pkg::CODE_W-1:0]   count_reg  [NUM_KEYS];
    logic [kdeq_pkg::CODE_W-1:0]   count_next [NUM_KEYS];
    logic [kdeq_pkg::CODE_W-1:0]   count_dec  [NUM_KEYS];
    logic [2*NUM_KEYS-1:0]         event_mask;
    logic [kdeq_pkg::MAX_KEYS-1:0] pins_ext;
    logic                          accept_tick;

    assign pins_ext    = kdeq_pkg::MAX_KEYS'(in_pins);
    assign accept_tick = in_valid && q_ready && (in_cmd == kdeq_pkg::CMD_TICK);

    // Each key contributes a release bit and then a press bit, in queueing order.
    always_comb begin
        event_mask = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            count_dec[k] = (count_reg[k] != '0) ? count_reg[k] - 1'b1 : '0;
            event_mask[2*k] = (count_reg[k] != '0) && (count_dec[k] == '0);
            event_mask[2*k+1] = !pins_ext[k] && (count_dec[k] == '0);
            count_next[k] = !pins_ext[k] ? ticks_reg : count_dec[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= kdeq_pkg::DEBOUNCE_RESET;
            for (int k = 0; k < NUM_KEYS; k++) begin
                count_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                ticks_reg <= cfg_wr_data;
            end
            if (accept_tick) begin
                for (int k = 0; k < NUM_KEYS; k++) begin
                    count_reg[k] <= count_next[k];
                end
            end
        end
    end

    assign q_valid = in_valid;
    assign q_data  = (in_cmd == kdeq_pkg::CMD_READ) ? {{(2*NUM_KEYS){1'b0}}, 1'b1}
                                                    : {event_mask, 1'b0};

endmodule

// ----- hdl/kdeq_cmd_fifo.sv -----
module kdeq_cmd_fifo #(
    parameter int WIDTH = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_pop,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/kdeq_back.sv -----
module kdeq_back #(
    parameter int NUM_KEYS   = kdeq_pkg::NUM_KEYS_DEFAULT,
    parameter int FIFO_DEPTH = kdeq_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  logic [2*NUM_KEYS:0]         q_data,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [kdeq_pkg::CODE_W-1:0] m_code
);

    localparam int MW = 2 * NUM_KEYS;
    localparam int IW = (MW > 1) ? $clog2(MW) : 1;
    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

    logic                        cur_valid_reg, cur_valid_next;
    logic                        cur_read_reg,  cur_read_next;
    logic [MW-1:0]               cur_mask_reg,  cur_mask_next;
    logic [AW-1:0]               rd_idx_reg,    rd_idx_next;
    logic [AW-1:0]               wr_idx_reg,    wr_idx_next;
    logic                        rd_pend_reg,   rd_pend_next;
    logic                        rd_zero_reg,   rd_zero_next;
    logic                        m_valid_reg,   m_valid_next;
    logic [kdeq_pkg::CODE_W-1:0] m_code_reg,    m_code_next;

    logic [MW-1:0]               low_bit;
    logic [MW-1:0]               mask_rest;
    logic [IW-1:0]               low_idx;
    logic [kdeq_pkg::CODE_W-1:0] evt_code;
    logic [kdeq_pkg::CODE_W-1:0] ram_q;
    logic [AW-1:0]               wr_idx_inc;
    logic [AW-1:0]               rd_idx_inc;
    logic                        full;
    logic                        empty;
    logic                        out_ready;
    logic                        can_issue;
    logic                        push_evt;
    logic                        issue;
    logic                        done;
    logic                        take;

    assign low_bit   = cur_mask_reg & (~cur_mask_reg + 1'b1);
    assign mask_rest = cur_mask_reg & ~low_bit;

    always_comb begin
        low_idx = '0;
        for (int j = 0; j < MW; j++) begin
            if (low_bit[j]) begin
                low_idx = IW'(j);
            end
        end
    end

    // Even bits are releases, odd bits presses; the key number is the bit pair.
    assign evt_code = (kdeq_pkg::PRESS_BASE + kdeq_pkg::CODE_W'(low_idx >> 1))
                    | (low_idx[0] ? '0 : kdeq_pkg::RELEASE_FLAG);

    assign wr_idx_inc = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_inc = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
    assign full       = (wr_idx_inc == rd_idx_reg);
    assign empty      = (wr_idx_reg == rd_idx_reg);
    assign out_ready  = !m_valid_reg || m_ready;
    assign can_issue  = !rd_pend_reg || out_ready;

    always_comb begin
        push_evt = 1'b0;
        issue    = 1'b0;
        done     = 1'b0;
        cur_mask_next = cur_mask_reg;
        if (cur_valid_reg) begin
            if (cur_read_reg) begin
                issue = can_issue;
                done  = can_issue;
            end else begin
                push_evt      = (cur_mask_reg != '0);
                cur_mask_next = mask_rest;
                done          = (mask_rest == '0);
            end
        end
        take  = !cur_valid_reg || done;
        q_pop = take && q_valid;
        cur_valid_next = take ? q_valid : cur_valid_reg;
        cur_read_next  = cur_read_reg;
        if (take && q_valid) begin
            cur_read_next = q_data[0];
            cur_mask_next = q_data[MW:1];
        end
    end

    always_comb begin
        wr_idx_next  = (push_evt && !full) ? wr_idx_inc : wr_idx_reg;
        rd_idx_next  = (issue && !empty) ? rd_idx_inc : rd_idx_reg;
        rd_zero_next = issue ? empty : rd_zero_reg;
        rd_pend_next = issue ? 1'b1 : (out_ready ? 1'b0 : rd_pend_reg);
        m_valid_next = out_ready ? rd_pend_reg : m_valid_reg;
        m_code_next  = m_code_reg;
        if (out_ready && rd_pend_reg) begin
            m_code_next = rd_zero_reg ? kdeq_pkg::EMPTY_CODE : ram_q;
        end
    end

    kdeq_ram #(
        .WIDTH (kdeq_pkg::CODE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (push_evt && !full),
        .wr_addr (wr_idx_reg),
        .wr_data (evt_code),
        .rd_en   (issue && !empty),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            rd_pend_reg   <= rd_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_read_reg <= cur_read_next;
        cur_mask_reg <= cur_mask_next;
        rd_zero_reg  <= rd_zero_next;
        m_code_reg   <= m_code_next;
    end

    assign m_valid = m_valid_reg;
    assign m_code  = m_code_reg;

endmodule

// ----- hdl/key_debounce_event_queue_unit.sv -----
// A read item passes the command FIFO, the item register, the RAM read register and the
// m_tdata register in turn. Throughput: one item per cycle, while a pending read is not
// stalled by m_tready, for reads and for ticks that raise at most one event; a tick
// queues or drops its events one per cycle, as the event RAM has a single write port.
// Reset: aresetn is synchronous and active low; it clears the debounce counts, the
// queue indices and all valid flags, and loads the debounce period with 20 ticks.
module key_debounce_event_queue_unit #(
    parameter int NUM_KEYS   = kdeq_pkg::NUM_KEYS_DEFAULT,
    parameter int FIFO_DEPTH = kdeq_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [2:0] key_pins, [7:3] zero
    input  logic [0:0] s_tuser,   // [0] cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] key_code
);

    localparam int QW = 2 * NUM_KEYS + 1;

    logic          fr_valid;
    logic [QW-1:0] fr_data;
    logic          q_ready;
    logic          q_valid;
    logic [QW-1:0] q_data;
    logic          q_pop;

    kdeq_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_cmd      (s_tuser[0]),
        .in_pins     (s_tdata[kdeq_pkg::PIN_W-1:0]),
        .q_ready     (q_ready),
        .q_valid     (fr_valid),
        .q_data      (fr_data)
    );

    kdeq_cmd_fifo #(
        .WIDTH (QW)
    ) u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (q_ready),
        .wr_data  (fr_data),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    kdeq_back #(
        .NUM_KEYS   (NUM_KEYS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_code  (m_tdata)
    );

    assign s_tready = q_ready;

endmodule

// ----- hdl/kdeq_checker.sv -----
module kdeq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A result is either the empty code or a press or release code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == kdeq_pkg::EMPTY_CODE || m_tdata[6:3] == 4'b0110))
        else $error("result is not a key code");

    // No result is offered in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // The input is ready in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready straight after reset");

endmodule

bind key_debounce_event_queue_unit kdeq_checker u_kdeq_checker (.*);

// ----- verif/tb.sv -----
module tb;

    localparam int NKEYS       = kdeq_pkg::NUM_KEYS_DEFAULT;
    localparam int RING_SLOTS  = kdeq_pkg::FIFO_DEPTH_DEFAULT;
    localparam int RING_IDX_W  = $clog2(RING_SLOTS);
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 16;

    typedef struct packed {
        logic                       cmd;
        logic [kdeq_pkg::PIN_W-1:0] pins;
    } key_item_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'd0;
    logic [0:0] s_tuser     = kdeq_pkg::CMD_TICK;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;

    key_item_t                   pending_items[$];
    logic [kdeq_pkg::CODE_W-1:0] expected_codes[$];

    logic [kdeq_pkg::CODE_W-1:0] debounce_period = kdeq_pkg::DEBOUNCE_RESET;
    logic [kdeq_pkg::CODE_W-1:0] key_count[NKEYS];
    logic [kdeq_pkg::CODE_W-1:0] event_ring[RING_SLOTS];
    logic [RING_IDX_W-1:0]       ring_rd = '0;
    logic [RING_IDX_W-1:0]       ring_wr = '0;

    int send_idle_pct = 17;
    int recv_idle_pct = 74;
    int items_queued  = 0;
    int items_sent    = 0;
    int reads_sent    = 0;
    int codes_checked = 0;
    int failures      = 0;
    int cycle_count   = 0;

    key_debounce_event_queue_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        for (int k = 0; k < NKEYS; k++) key_count[k] = '0;
        for (int i = 0; i < RING_SLOTS; i++) event_ring[i] = '0;
    end

    function automatic void push_event(logic [kdeq_pkg::CODE_W-1:0] code);
        logic [RING_IDX_W-1:0] next_wr;
        next_wr = ring_wr + 1'b1;
        if (next_wr != ring_rd) begin
            event_ring[ring_wr] = code;
            ring_wr = next_wr;
        end
    endfunction

    function automatic void scan_keys(logic [kdeq_pkg::PIN_W-1:0] pins);
        logic [kdeq_pkg::PIN_W-1:0]  pressed;
        logic [kdeq_pkg::CODE_W-1:0] code;
        pressed = ~pins;
        for (int k = 0; k < NKEYS; k++) begin
            code = kdeq_pkg::PRESS_BASE + kdeq_pkg::CODE_W'(k);
            if (key_count[k] != '0) begin
                key_count[k] = key_count[k] - 1'b1;
                if (key_count[k] == '0) push_event(code | kdeq_pkg::RELEASE_FLAG);
            end
            if (pressed[k]) begin
                if (key_count[k] == '0) push_event(code);
                key_count[k] = debounce_period;
            end
        end
    endfunction

    function automatic logic [kdeq_pkg::CODE_W-1:0] pop_event();
        logic [kdeq_pkg::CODE_W-1:0] code;
        code = kdeq_pkg::EMPTY_CODE;
        if (ring_rd != ring_wr) begin
            code = event_ring[ring_rd];
            ring_rd = ring_rd + 1'b1;
        end
        return code;
    endfunction

    always @(posedge aclk) begin : drive_items
        key_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                items_sent++;
                if (s_tuser[0] == kdeq_pkg::CMD_READ) begin
                    reads_sent++;
                    expected_codes.push_back(pop_event());
                end else begin
                    scan_keys(s_tdata[kdeq_pkg::PIN_W-1:0]);
                end
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(8-kdeq_pkg::PIN_W){1'b0}}, item.pins};
                    s_tuser  <= item.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_codes
        logic [kdeq_pkg::CODE_W-1:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_codes.size() == 0) begin
                    $error("key_code %0h arrived with no read outstanding", m_tdata);
                    failures++;
                end else begin
                    want = expected_codes.pop_front();
                    codes_checked++;
                    if (m_tdata !== want) begin
                        $error("key_code mismatch: expected %0h, actual %0h", want, m_tdata);
                        failures++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_item(logic cmd, logic [kdeq_pkg::PIN_W-1:0] pins);
        key_item_t item;
        item.cmd  = cmd;
        item.pins = pins;
        pending_items.push_back(item);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (items_sent != items_queued || expected_codes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_debounce(logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        debounce_period = value;
    endtask

    // Keys are held and let go as a user would, with some raw noise and reads mixed in.
    task automatic add_random_items(int count);
        logic [kdeq_pkg::PIN_W-1:0] held;
        int                         roll;
        held = '0;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                add_item(kdeq_pkg::CMD_READ, kdeq_pkg::PIN_W'($urandom_range(7)));
            end else if (roll < 92) begin
                for (int k = 0; k < NKEYS; k++)
                    if ($urandom_range(5) == 0) held[k] = ~held[k];
                add_item(kdeq_pkg::CMD_TICK, ~held);
            end else begin
                add_item(kdeq_pkg::CMD_TICK, kdeq_pkg::PIN_W'($urandom_range(7)));
            end
        end
    endtask

    initial begin
        logic [7:0] random_periods[6];
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset period: reads of an empty queue, presses, holds and pins on reads.
        add_item(kdeq_pkg::CMD_READ, 3'b000);
        add_item(kdeq_pkg::CMD_TICK, 3'b111);
        add_item(kdeq_pkg::CMD_TICK, 3'b000);
        add_item(kdeq_pkg::CMD_TICK, 3'b000);
        repeat (3) add_item(kdeq_pkg::CMD_READ, 3'b111);
        add_item(kdeq_pkg::CMD_READ, 3'b101);
        add_item(kdeq_pkg::CMD_TICK, 3'b110);
        wait_drained();

        // Shortest period: releases follow at once and the last reads find the queue empty.
        set_debounce(8'd1);
        add_item(kdeq_pkg::CMD_TICK, 3'b111);
        add_item(kdeq_pkg::CMD_TICK, 3'b000);
        add_item(kdeq_pkg::CMD_TICK, 3'b111);
        add_item(kdeq_pkg::CMD_TICK, 3'b000);
        repeat (8) add_item(kdeq_pkg::CMD_READ, 3'b010);
        wait_drained();

        // A zero period repeats the press on every tick; only counts left from the period before release.
        set_debounce(8'd0);
        add_item(kdeq_pkg::CMD_TICK, 3'b110);
        add_item(kdeq_pkg::CMD_TICK, 3'b110);
        add_item(kdeq_pkg::CMD_TICK, 3'b011);
        repeat (4) add_item(kdeq_pkg::CMD_READ, 3'b000);
        wait_drained();

        random_periods[0] = 8'd1;
        random_periods[1] = 8'd255;
        random_periods[2] = 8'd3;
        random_periods[3] = 8'($urandom_range(2, 8));
        random_periods[4] = 8'd2;
        random_periods[5] = 8'($urandom_range(1, 12));
        for (int p = 0; p < 6; p++) begin
            if (p < 2) begin
                send_idle_pct = 17;
                recv_idle_pct = 74;
            end else if (p < 4) begin
                send_idle_pct = 74;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_debounce(random_periods[p]);
            add_random_items(270);
            wait_drained();
        end

        $display("Sent %0d items, %0d of them reads; %0d key codes checked.",
                 items_sent, reads_sent, codes_checked);
        $display("Debounce periods ran from 0 to 255 under three idling patterns.");
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
